// ----- rtl/core/i2rd_pkg.sv -----
// i2rd_pkg: shared widths and types for the integer to radix digits core
// no dependencies; imported by every module in rtl/core
`timescale 1ns / 1ps

package i2rd_pkg;

   localparam int VALUE_BITS = 31;
   localparam int RADIX_W    = 9;
   localparam int DIGIT_W    = 8;
   localparam int STACK_DEPTH = VALUE_BITS;
   localparam int COUNT_W    = $clog2(STACK_DEPTH + 1);
   localparam int BIT_CNT_W  = $clog2(VALUE_BITS);

   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(256);
   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [DIGIT_W-1:0]    digit_type;
   typedef logic [RADIX_W-1:0]    radix_type;
   typedef logic [COUNT_W-1:0]    count_type;

   // digit stack control
   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

   // divider result bundle
   typedef struct packed {
      logic      done;
      value_type quotient;
      digit_type remainder;
   } div_status_type;

endpackage

// ----- rtl/core/i2rd_div.sv -----
// i2rd_div: bit-serial restoring divider, one quotient bit per cycle
// depends on i2rd_pkg
`timescale 1ns / 1ps

module i2rd_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  i2rd_pkg::value_type     dividend,
   input  i2rd_pkg::radix_type     radix,
   output i2rd_pkg::div_status_type status
);
   import i2rd_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [BIT_CNT_W-1:0] cnt_ff, cnt_in;
   value_type            quo_ff, quo_in;
   digit_type            rem_ff, rem_in;

   logic [RADIX_W-1:0]   trial;
   logic                 qbit;

   // partial remainder shifted left with the next dividend bit
   assign trial = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign qbit  = (trial >= radix);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (load) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_BITS-2:0], qbit};
         rem_in = qbit ? DIGIT_W'(trial - radix) : trial[DIGIT_W-1:0];
         cnt_in = cnt_ff + BIT_CNT_W'(1);
         if (cnt_ff == BIT_CNT_W'(VALUE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign status.done      = done_ff;
   assign status.quotient  = quo_ff;
   assign status.remainder = rem_ff;

   a_load_starts : assert property (@(posedge clock) disable iff (reset)
      load |=> busy_ff && !done_ff)
      else $error("divider did not start on load");

   a_done_ends : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still iterating");

endmodule

// ----- rtl/core/i2rd_stack.sv -----
// i2rd_stack: shift-register digit stack, pushes least significant first,
// pops most significant first; depends on i2rd_pkg
`timescale 1ns / 1ps

module i2rd_stack (
   input  logic                   clock,
   input  logic                   reset,
   input  i2rd_pkg::stack_ctl_type ctl,
   input  i2rd_pkg::digit_type    push_digit,
   output i2rd_pkg::digit_type    top_digit,
   output i2rd_pkg::count_type    level
);
   import i2rd_pkg::*;

   digit_type entry_ff [STACK_DEPTH];
   digit_type entry_in [STACK_DEPTH];
   count_type count_ff, count_in;

   always_comb begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
         entry_in[i] = entry_ff[i];
      end
      count_in = count_ff;
      if (ctl.push) begin
         entry_in[0] = push_digit;
         for (int i = 1; i < STACK_DEPTH; i++) begin
            entry_in[i] = entry_ff[i-1];
         end
         count_in = count_ff + COUNT_W'(1);
      end else if (ctl.pop) begin
         for (int i = 0; i < STACK_DEPTH - 1; i++) begin
            entry_in[i] = entry_ff[i+1];
         end
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      for (int i = 0; i < STACK_DEPTH; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

   assign top_digit = entry_ff[0];
   assign level     = count_ff;

   a_level_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(STACK_DEPTH))
      else $error("digit stack overflow");

endmodule

// ----- rtl/core/integer_to_radix_digits_core.sv -----
// integer_to_radix_digits_core: top level, radix register, sequencer
// depends on i2rd_pkg, i2rd_div, i2rd_stack
//
//   port group  direction  handshake            beat contents
//   req_        in         start / busy         value
//   rsp_        out        rsp_valid strobe     digit, last
//   csr_        in         csr_valid/csr_ready  radix (9 bits)
//
// each digit takes a full pass of the bit-serial divider, then the digits
// stream out one per cycle.
// busy stays high from the accepted start until the last digit's beat.
// reset is synchronous; it sets the radix to 10 and empties the digit stack.
// rsp beats are single-cycle strobes; the receiver cannot stall them.
`timescale 1ns / 1ps

module integer_to_radix_digits_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  i2rd_pkg::value_type req_value,
   output logic                rsp_valid,
   output i2rd_pkg::digit_type rsp_digit,
   output logic                rsp_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  i2rd_pkg::radix_type csr_data
);
   import i2rd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type      state_ff, state_in;
   radix_type      radix_ff, radix_in;
   logic           div_load;
   value_type      div_dividend;
   div_status_type div_stat;
   stack_ctl_type  stk_ctl;
   digit_type      stk_top;
   count_type      stk_level;

   // out-of-range radix values saturate into 2..256
   always_comb begin
      radix_in = radix_ff;
      if (csr_valid && csr_ready) begin
         if (csr_data < RADIX_MIN) begin
            radix_in = RADIX_MIN;
         end else if (csr_data > RADIX_MAX) begin
            radix_in = RADIX_MAX;
         end else begin
            radix_in = csr_data;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      div_load     = 1'b0;
      div_dividend = req_value;
      stk_ctl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               div_load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               stk_ctl.push = 1'b1;
               // keep dividing until the quotient runs out
               if (div_stat.quotient == '0) begin
                  state_in = ST_EMIT;
               end else begin
                  div_load     = 1'b1;
                  div_dividend = div_stat.quotient;
               end
            end
         end
         ST_EMIT: begin
            stk_ctl.pop = 1'b1;
            if (stk_level == COUNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         radix_ff <= RADIX_RESET;
      end else begin
         state_ff <= state_in;
         radix_ff <= radix_in;
      end
   end

   i2rd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .dividend (div_dividend),
      .radix    (radix_ff),
      .status   (div_stat)
   );

   i2rd_stack u_stack (
      .clock      (clock),
      .reset      (reset),
      .ctl        (stk_ctl),
      .push_digit (div_stat.remainder),
      .top_digit  (stk_top),
      .level      (stk_level)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_digit = stk_top;
   assign rsp_last  = (state_ff == ST_EMIT) && (stk_level == COUNT_W'(1));

   a_emit_nonempty : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> stk_level != '0)
      else $error("digit beat from an empty stack");

   a_last_frees : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !busy && stk_level == '0)
      else $error("core still busy after the last digit");

   a_radix_range : assert property (@(posedge clock) disable iff (reset)
      radix_ff >= RADIX_MIN && radix_ff <= RADIX_MAX)
      else $error("radix register out of range");

endmodule
